/* rtl/u8d_pkg.sv */
// u8d_pkg: shared types, constants and helper functions of the utf-8 stream decoder
// used by every module of the decoder; depends on nothing
`default_nettype none

package u8d_pkg;

    // default depth of the queue between classifier and output stage
    localparam int unsigned QUEUE_DEPTH = 2;

    // widths of the stream fields
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 32;
    localparam int unsigned PEND_W = 3;
    localparam int unsigned KCNT_W = 4;

    // continuation byte: top two bits are 10, low six bits carry payload
    localparam logic [1:0] CONT_TAG     = 2'b10;
    localparam int unsigned PAYLOAD_W   = 6;

    // one queue entry: up to two results caused by one input byte
    // result a is always an early-stopped partial value (cut_short 1)
    // result b is always a complete value (cut_short 0, last 1)
    typedef struct packed {
        logic            a_valid;
        logic [CP_W-1:0] a_value;
        logic            b_valid;
        logic [CP_W-1:0] b_value;
    } entry_t;

    // write side of the queue
    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

    // read side of the queue
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    // number of leading one bits of a byte, 0 to 8
    function automatic logic [KCNT_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
        logic [KCNT_W-1:0] n;
        logic              run;
        n   = '0;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            run = run & b[i];
            n   = n + KCNT_W'(run);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/utf8_stream_decoder_core.sv */
// utf8_stream_decoder_core: top level of the utf-8 byte stream to code point decoder
// depends on u8d_pkg, u8d_front, u8d_queue and u8d_back
`default_nettype none

// Decodes a UTF-8 byte stream into code points without validation. One byte is
// accepted per clock while the queue is not full; each byte yields zero, one
// or two result words. A word passes from the classifier into the queue and
// then into the output register. While m_axis_tready is high the output
// register sends one word per cycle, so the sustained rate is one byte per
// cycle, except that a byte which both ends a sequence early and forms a
// one-byte code point yields two words. A partial value cut short by a
// non-continuation byte is flagged in tuser; tlast marks the final word caused
// by one input byte. Values wrap to 32 bits for overlong lead bytes.
module utf8_stream_decoder_core
#(
    parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH  // 2 or more
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input byte stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,    // [7:0] byte_in
    // decoded code points
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,    // [31:0] code_point
    output logic              m_axis_tuser,    // [0] cut_short
    output logic              m_axis_tlast
);

    u8d_pkg::push_t push;
    u8d_pkg::head_t head;
    logic           queue_full;
    logic           pop;

    // classifier and sequence state
    u8d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .queue_full (queue_full),
        .push       (push)
    );

    // entry queue
    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    // word sequencing and output register
    u8d_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_code_point (m_axis_tdata),
        .out_cut_short  (m_axis_tuser),
        .out_last       (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* rtl/u8d_front.sv */
// u8d_front: accepts raw bytes, tracks the pending sequence and builds queue entries
// depends on u8d_pkg
`default_nettype none

module u8d_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [u8d_pkg::BYTE_W-1:0]    in_byte,
    input  wire logic                          queue_full,
    output u8d_pkg::push_t                     push
);

    logic [u8d_pkg::PEND_W-1:0] pending_reg, pending_next;
    logic [u8d_pkg::CP_W-1:0]   partial_reg, partial_next;

    logic                        accept;
    logic                        is_cont;
    logic [u8d_pkg::KCNT_W-1:0]  k;
    logic [u8d_pkg::BYTE_W-1:0]  lead_mask;
    logic [u8d_pkg::CP_W-1:0]    lead_value;
    logic [u8d_pkg::CP_W-1:0]    ext_value;
    u8d_pkg::entry_t             entry;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // byte classification
    assign is_cont    = (in_byte[7:6] == u8d_pkg::CONT_TAG);
    assign k          = u8d_pkg::lead_ones(in_byte);
    assign lead_mask  = {u8d_pkg::BYTE_W{1'b1}} >> k;
    assign lead_value = u8d_pkg::CP_W'(in_byte & lead_mask);
    assign ext_value  = {partial_reg[u8d_pkg::CP_W-u8d_pkg::PAYLOAD_W-1:0],
                         in_byte[u8d_pkg::PAYLOAD_W-1:0]};

    // next state and results for this byte
    always_comb
    begin
        entry        = '0;
        pending_next = pending_reg;
        partial_next = partial_reg;
        if ((pending_reg != '0) && is_cont)
        begin
            // extend the pending value
            partial_next = ext_value;
            pending_next = pending_reg - 1'b1;
            if (pending_reg == u8d_pkg::PEND_W'(1))
            begin
                entry.b_valid = 1'b1;
                entry.b_value = ext_value;
                partial_next  = '0;
            end
        end
        else
        begin
            // early stop flushes the partial value
            if (pending_reg != '0)
            begin
                entry.a_valid = 1'b1;
                entry.a_value = partial_reg;
            end
            // byte acts as a lead
            if (k <= u8d_pkg::KCNT_W'(1))
            begin
                entry.b_valid = 1'b1;
                entry.b_value = lead_value;
                partial_next  = '0;
                pending_next  = '0;
            end
            else
            begin
                partial_next = lead_value;
                pending_next = u8d_pkg::PEND_W'(k - 1'b1);
            end
        end
    end

    assign push.push  = accept && (entry.a_valid || entry.b_valid);
    assign push.entry = entry;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/u8d_queue.sv */
// u8d_queue: short register queue of result entries between front and back
// depends on u8d_pkg
`default_nettype none

module u8d_queue
#(
    parameter int unsigned DEPTH = u8d_pkg::QUEUE_DEPTH  // 2 or more
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire u8d_pkg::push_t push,
    input  wire logic           pop,
    output logic                full,
    output u8d_pkg::head_t      head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    u8d_pkg::entry_t   entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = entries_reg[rd_ptr_reg];

    assign do_push = push.push && !full;
    assign do_pop  = pop && head.valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/u8d_back.sv */
// u8d_back: splits queue entries into single result words and drives the output register
// depends on u8d_pkg
`default_nettype none

module u8d_back
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire u8d_pkg::head_t             head,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [u8d_pkg::CP_W-1:0]        out_code_point,
    output logic                            out_cut_short,
    output logic                            out_last
);

    logic                      valid_reg, valid_next;
    logic [u8d_pkg::CP_W-1:0]  cp_reg, cp_next;
    logic                      cut_reg, cut_next;
    logic                      last_reg, last_next;
    logic                      a_done_reg, a_done_next;
    logic                      load;
    logic                      emit_a;

    // load a new word when the output register is free or being taken
    assign load   = head.valid && (!valid_reg || out_ready);
    assign emit_a = head.entry.a_valid && !a_done_reg;
    assign pop    = load && !(emit_a && head.entry.b_valid);

    always_comb
    begin
        valid_next  = valid_reg;
        cp_next     = cp_reg;
        cut_next    = cut_reg;
        last_next   = last_reg;
        a_done_next = a_done_reg;
        if (load)
        begin
            valid_next  = 1'b1;
            cp_next     = emit_a ? head.entry.a_value : head.entry.b_value;
            cut_next    = emit_a;
            last_next   = emit_a ? !head.entry.b_valid : 1'b1;
            a_done_next = emit_a && head.entry.b_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            a_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            a_done_reg <= a_done_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        cut_reg  <= cut_next;
        last_reg <= last_next;
    end

    assign out_valid      = valid_reg;
    assign out_code_point = cp_reg;
    assign out_cut_short  = cut_reg;
    assign out_last       = last_reg;

`ifndef SYNTHESIS
    // half-sent entry: the partial word sits in the output register
    a_done_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        a_done_reg == (valid_reg && !last_reg))
        else $error("split entry state out of step with output register");

    // a split entry keeps its second word in the queue
    a_done_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        a_done_reg |-> head.valid)
        else $error("split entry lost from queue");

    // only an early-stopped word can be followed by another for the same byte
    not_last_is_cut: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> cut_reg)
        else $error("non-final word without cut_short");
`endif

endmodule

`default_nettype wire
